@@ design/sfd_pkg.sv @@
// Package for the sensor frame deframer: types, widths and reset constants.
`timescale 1ns / 1ps

package sfd_pkg;

    // Default largest payload a frame may declare
    localparam int unsigned PAYLOAD_MAX_DEFAULT = 16;

    // Field widths
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned INDEX_W    = 4;
    localparam int unsigned PLEN_W     = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned TDATA_IN_W = 8;
    localparam int unsigned TDATA_W    = 40;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST   = 8'h53;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST  = 8'h59;
    localparam logic [BYTE_W-1:0] TRAILER_FIRST_RST  = 8'h54;
    localparam logic [BYTE_W-1:0] TRAILER_SECOND_RST = 8'h43;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST   = 2'd0,
        CFG_HEADER_SECOND  = 2'd1,
        CFG_TRAILER_FIRST  = 2'd2,
        CFG_TRAILER_SECOND = 2'd3
    } cfg_index_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_SUM_GOOD = 2'd1,
        KIND_SUM_BAD  = 2'd2,
        KIND_COMPLETE = 2'd3
    } kind_t;

    // Parser states
    typedef enum logic [3:0] {
        ST_HUNT  = 4'd0,
        ST_HDR2  = 4'd1,
        ST_CTRL  = 4'd2,
        ST_CMD   = 4'd3,
        ST_LENHI = 4'd4,
        ST_LENLO = 4'd5,
        ST_DATA  = 4'd6,
        ST_SUM   = 4'd7,
        ST_TRL1  = 4'd8,
        ST_TRL2  = 4'd9
    } parse_state_t;

endpackage

@@ design/sensor_frame_deframer.sv @@
// Top level of the sensor frame deframer: byte stream in, frame events out.
`timescale 1ns / 1ps

// Channel   Direction  Width         Contents
// s_axis    in         tdata 8       rx_byte
// m_axis    out        tdata 40      frame fields, tuser 2 = kind
// cfg       in         index 2, 8    header/trailer match bytes
//
// One byte is taken per cycle while the output is not stalled; a byte is
// registered on transfer and parsed once the output slot is free, its result
// (if any) landing in the output register.
// A stalled output holds the parser; the input register takes a byte only
// while it is empty or being parsed, so one byte at most waits behind a held result.
// rst_n clears parser state and restores the default match bytes.

module sensor_frame_deframer #(
    parameter int unsigned PAYLOAD_MAX = sfd_pkg::PAYLOAD_MAX_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfd_pkg::TDATA_IN_W-1:0]  s_tdata,   // [7:0] rx_byte
    // Output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfd_pkg::TDATA_W-1:0]     m_tdata,   // [7:0] control_word,
                                                       // [15:8] command_word,
                                                       // [19:16] byte_index,
                                                       // [27:20] payload_byte,
                                                       // [32:28] payload_length,
                                                       // [39:33] zero
    output logic [sfd_pkg::KIND_W-1:0]      m_tuser,   // [1:0] kind
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]      cfg_data
);

    import sfd_pkg::*;

    localparam int unsigned LEN_W = $clog2(PAYLOAD_MAX + 1);
    localparam logic [15:0] LEN_LIMIT = 16'(PAYLOAD_MAX);

    // Configuration registers
    logic [BYTE_W-1:0] header_first_reg;
    logic [BYTE_W-1:0] header_second_reg;
    logic [BYTE_W-1:0] trailer_first_reg;
    logic [BYTE_W-1:0] trailer_second_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Parser state
    parse_state_t      state_reg, state_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] control_reg, control_next;
    logic [BYTE_W-1:0] command_reg, command_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  seen_reg, seen_next;

    // Output register
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [BYTE_W-1:0]  out_control_reg;
    logic [BYTE_W-1:0]  out_command_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [PLEN_W-1:0]  out_length_reg;

    // Result of the current byte
    logic               emit;
    kind_t              emit_kind;
    logic [INDEX_W-1:0] emit_index;
    logic [BYTE_W-1:0]  emit_byte;

    logic        advance;
    logic [15:0] len_full;
    logic [15:0] length_wide;
    logic [15:0] seen_wide;
    logic [LEN_W-1:0] seen_inc;

    // Handshake: parse when a byte waits and the output slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign len_full    = {len_hi_reg, in_byte_reg};
    assign length_wide = 16'(length_reg);
    assign seen_wide   = 16'(seen_reg);
    assign seen_inc    = seen_reg + LEN_W'(1);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg   <= HEADER_FIRST_RST;
            header_second_reg  <= HEADER_SECOND_RST;
            trailer_first_reg  <= TRAILER_FIRST_RST;
            trailer_second_reg <= TRAILER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEADER_FIRST:   header_first_reg   <= cfg_data;
                CFG_HEADER_SECOND:  header_second_reg  <= cfg_data;
                CFG_TRAILER_FIRST:  trailer_first_reg  <= cfg_data;
                CFG_TRAILER_SECOND: trailer_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser next state and result
    always_comb
    begin
        state_next   = ST_HUNT;
        sum_next     = sum_reg;
        control_next = control_reg;
        command_next = command_reg;
        len_hi_next  = len_hi_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        emit         = 1'b0;
        emit_kind    = KIND_PAYLOAD;
        emit_index   = '0;
        emit_byte    = '0;

        unique case (state_reg)
            ST_HDR2:
            begin
                if (in_byte_reg == header_second_reg)
                begin
                    sum_next   = sum_reg + in_byte_reg;
                    state_next = ST_CTRL;
                end
            end
            ST_CTRL:
            begin
                control_next = in_byte_reg;
                sum_next     = sum_reg + in_byte_reg;
                state_next   = ST_CMD;
            end
            ST_CMD:
            begin
                command_next = in_byte_reg;
                sum_next     = sum_reg + in_byte_reg;
                state_next   = ST_LENHI;
            end
            ST_LENHI:
            begin
                len_hi_next = in_byte_reg;
                sum_next    = sum_reg + in_byte_reg;
                state_next  = ST_LENLO;
            end
            ST_LENLO:
            begin
                sum_next  = sum_reg + in_byte_reg;
                seen_next = '0;
                // Oversize frames are dropped; the length register takes the low bits either way
                length_next = len_full[LEN_W-1:0];
                if (len_full > LEN_LIMIT)
                begin
                    state_next = ST_HUNT;
                end
                else if (len_full == 16'd0)
                begin
                    state_next = ST_SUM;
                end
                else
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                sum_next   = sum_reg + in_byte_reg;
                emit       = 1'b1;
                emit_kind  = KIND_PAYLOAD;
                emit_index = seen_wide[INDEX_W-1:0];
                emit_byte  = in_byte_reg;
                seen_next  = seen_inc;
                state_next = (seen_inc >= length_reg) ? ST_SUM : ST_DATA;
            end
            ST_SUM:
            begin
                emit = 1'b1;
                if (in_byte_reg == sum_reg)
                begin
                    emit_kind  = KIND_SUM_GOOD;
                    state_next = ST_TRL1;
                end
                else
                begin
                    emit_kind  = KIND_SUM_BAD;
                    state_next = ST_HUNT;
                end
            end
            ST_TRL1:
            begin
                state_next = (in_byte_reg == trailer_first_reg) ? ST_TRL2 : ST_HUNT;
            end
            ST_TRL2:
            begin
                if (in_byte_reg == trailer_second_reg)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_COMPLETE;
                end
            end
            default:
            begin
                // Hunting, and any unused code
                if (in_byte_reg == header_first_reg)
                begin
                    sum_next   = in_byte_reg;
                    state_next = ST_HDR2;
                end
            end
        endcase
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HUNT;
            sum_reg     <= '0;
            control_reg <= '0;
            command_reg <= '0;
            len_hi_reg  <= '0;
            length_reg  <= '0;
            seen_reg    <= '0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            control_reg <= control_next;
            command_reg <= command_next;
            len_hi_reg  <= len_hi_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
        end
    end

    // Output register: valid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg    <= emit_kind;
            out_control_reg <= control_reg;
            out_command_reg <= command_reg;
            out_index_reg   <= emit_index;
            out_byte_reg    <= emit_byte;
            out_length_reg  <= length_wide[PLEN_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_length_reg, out_byte_reg, out_index_reg,
                       out_command_reg, out_control_reg};

endmodule
